// ===== hdl/vrp_pkg.sv =====
// shared constants, register codes and types for the vertex rotate and project block
// no dependencies; imported by every module of the block
`default_nettype none

package vrp_pkg;

   localparam int COORD_W    = 24;
   localparam int TRIG_W     = 16;
   localparam int CTR_W      = 16;
   localparam int FOCAL_W    = 32;
   localparam int OUT_W      = 32;
   localparam int DEPTH_W    = 24;
   localparam int NUM_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int OUT_FRAC   = 16;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int TRIG_FRAC_BITS_DEF  = 14;

   localparam int DEPTH_MIN = 3277;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   // front stages before the divider, one bit per divider stage, one output stage
   localparam int FRONT_STAGES = 7;
   localparam int LATENCY      = FRONT_STAGES + NUM_W + 1;

   localparam logic signed [TRIG_W-1:0]  RST_COS   = TRIG_W'(16384);
   localparam logic signed [TRIG_W-1:0]  RST_SIN   = '0;
   localparam logic signed [CTR_W-1:0]   RST_CTR   = '0;
   localparam logic [FOCAL_W-1:0]        RST_FOCAL = FOCAL_W'(32'h0100_0000);

   localparam logic [CSR_IDX_W-1:0] CSR_COS_YAW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_YAW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_PITCH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_PITCH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL     = 3'd6;

   typedef struct packed {
      logic last;
      logic neg_x;
      logic neg_y;
   } vrp_tag_type;

endpackage

`default_nettype wire

// ===== hdl/vrp_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, two dividends per divisor
// depends on vrp_pkg
`default_nettype none

module vrp_div_pipe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire vrp_pkg::vrp_tag_type          in_tag,
   input  wire logic [vrp_pkg::DEPTH_W-1:0]   in_divisor,
   input  wire logic [vrp_pkg::NUM_W-1:0]     in_num_x,
   input  wire logic [vrp_pkg::NUM_W-1:0]     in_num_y,
   output logic                               out_valid,
   output vrp_pkg::vrp_tag_type               out_tag,
   output logic [vrp_pkg::DEPTH_W-1:0]        out_divisor,
   output logic [vrp_pkg::NUM_W-1:0]          out_quot_x,
   output logic [vrp_pkg::NUM_W-1:0]          out_quot_y
);
   import vrp_pkg::*;

   typedef struct packed {
      logic [DEPTH_W-1:0] rem;
      logic [NUM_W-1:0]   nq;
   } div_step_type;

   // remainder stays below the divisor; numerator bits leave at the top, quotient enters below
   function automatic div_step_type div_step(input logic [DEPTH_W-1:0] rem,
                                             input logic [NUM_W-1:0] nq,
                                             input logic [DEPTH_W-1:0] d);
      logic [DEPTH_W:0] top;
      div_step_type     r;
      top = {rem, nq[NUM_W-1]};
      if (top >= {1'b0, d}) begin
         r.rem = DEPTH_W'(top - {1'b0, d});
         r.nq  = {nq[NUM_W-2:0], 1'b1};
      end else begin
         r.rem = top[DEPTH_W-1:0];
         r.nq  = {nq[NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

   logic               valid_ff [NUM_W];
   vrp_tag_type        tag_ff   [NUM_W];
   logic [DEPTH_W-1:0] div_ff   [NUM_W];
   logic [DEPTH_W-1:0] rem_x_ff [NUM_W];
   logic [DEPTH_W-1:0] rem_y_ff [NUM_W];
   logic [NUM_W-1:0]   nq_x_ff  [NUM_W];
   logic [NUM_W-1:0]   nq_y_ff  [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic               v_prev;
      vrp_tag_type        t_prev;
      logic [DEPTH_W-1:0] d_prev;
      logic [DEPTH_W-1:0] rx_prev;
      logic [DEPTH_W-1:0] ry_prev;
      logic [NUM_W-1:0]   nx_prev;
      logic [NUM_W-1:0]   ny_prev;
      div_step_type       sx_in;
      div_step_type       sy_in;

      if (i == 0) begin : g_first
         assign v_prev  = in_valid;
         assign t_prev  = in_tag;
         assign d_prev  = in_divisor;
         assign rx_prev = '0;
         assign ry_prev = '0;
         assign nx_prev = in_num_x;
         assign ny_prev = in_num_y;
      end else begin : g_next
         assign v_prev  = valid_ff[i-1];
         assign t_prev  = tag_ff[i-1];
         assign d_prev  = div_ff[i-1];
         assign rx_prev = rem_x_ff[i-1];
         assign ry_prev = rem_y_ff[i-1];
         assign nx_prev = nq_x_ff[i-1];
         assign ny_prev = nq_y_ff[i-1];
      end

      assign sx_in = div_step(rx_prev, nx_prev, d_prev);
      assign sy_in = div_step(ry_prev, ny_prev, d_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         tag_ff[i]   <= t_prev;
         div_ff[i]   <= d_prev;
         rem_x_ff[i] <= sx_in.rem;
         rem_y_ff[i] <= sy_in.rem;
         nq_x_ff[i]  <= sx_in.nq;
         nq_y_ff[i]  <= sy_in.nq;
      end
   end

   assign out_valid   = valid_ff[NUM_W-1];
   assign out_tag     = tag_ff[NUM_W-1];
   assign out_divisor = div_ff[NUM_W-1];
   assign out_quot_x  = nq_x_ff[NUM_W-1];
   assign out_quot_y  = nq_y_ff[NUM_W-1];

endmodule

`default_nettype wire

// ===== hdl/vertex_rotate_project.sv =====
// an accepted vertex passes the front stages, the divider and the output register
// throughput: one vertex per cycle, busy stays low; set by the 64-stage divider pipeline
// results cannot be held off: each is shown for exactly one cycle on rsp_valid
// reset (synchronous, active high) clears all beats in flight and loads default registers
// top level; depends on vrp_pkg and vrp_div_pipe
`default_nettype none

module vertex_rotate_project #(
   parameter int COORD_FRAC_BITS = vrp_pkg::COORD_FRAC_BITS_DEF,
   parameter int TRIG_FRAC_BITS  = vrp_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [vrp_pkg::COORD_W-1:0]    req_vertex_x,
   input  wire logic signed [vrp_pkg::COORD_W-1:0]    req_vertex_y,
   input  wire logic signed [vrp_pkg::COORD_W-1:0]    req_vertex_z,
   input  wire logic                                  req_last_vertex,
   output logic                                       rsp_valid,
   output logic signed [vrp_pkg::OUT_W-1:0]           rsp_screen_x,
   output logic signed [vrp_pkg::OUT_W-1:0]           rsp_screen_y,
   output logic [vrp_pkg::DEPTH_W-1:0]                rsp_depth,
   output logic                                       rsp_last_out,
   input  wire logic                                  csr_wr_en,
   input  wire logic [vrp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [vrp_pkg::CSR_DATA_W-1:0]        csr_data
);
   import vrp_pkg::*;

   localparam int C       = COORD_FRAC_BITS;
   localparam int T       = TRIG_FRAC_BITS;
   localparam int PROD_W  = COORD_W + TRIG_W;
   localparam int ROT1_W  = PROD_W + 1;
   localparam int Z1P_W   = ROT1_W + TRIG_W;
   localparam int YP_W    = PROD_W + T;
   localparam int ROT2_W  = ((Z1P_W > YP_W) ? Z1P_W : YP_W) + 1;
   localparam int DF_W    = ((ROT2_W > C + 2*T + 3) ? ROT2_W : C + 2*T + 3) + 1;
   localparam int SX      = C + T - OUT_FRAC;
   localparam int SY      = C + 2*T - OUT_FRAC;
   localparam int QC_W    = OUT_W + 2;
   localparam int SUM_W   = OUT_W + 4;

   localparam logic signed [ROT1_W:0] HALF_X = (SX == 0) ? '0 : ((ROT1_W+1)'(1) << (SX - 1));
   localparam logic signed [ROT2_W:0] HALF_Y = (ROT2_W+1)'(1) << (SY - 1);
   localparam logic signed [DF_W:0]   HALF_D = (DF_W+1)'(1) << (SY - 1);
   localparam logic signed [DF_W-1:0] DEPTH_OFFSET = DF_W'(3) << (C + 2*T);

   localparam logic signed [OUT_W-1:0] S32_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] S32_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic signed [ROT1_W:0] X_MAX = (ROT1_W+1)'(S32_MAX);
   localparam logic signed [ROT1_W:0] X_MIN = (ROT1_W+1)'(S32_MIN);
   localparam logic signed [ROT2_W:0] Y_MAX = (ROT2_W+1)'(S32_MAX);
   localparam logic signed [ROT2_W:0] Y_MIN = (ROT2_W+1)'(S32_MIN);
   localparam logic signed [SUM_W-1:0] O_MAX = SUM_W'(S32_MAX);
   localparam logic signed [SUM_W-1:0] O_MIN = SUM_W'(S32_MIN);
   localparam logic signed [DF_W:0] R_MIN = (DF_W+1)'(DEPTH_MIN);
   localparam logic signed [DF_W:0] R_MAX = (DF_W+1)'({1'b0, DEPTH_MAX});
   localparam logic [NUM_W-1:0] Q_CAP = NUM_W'(1) << (QC_W - 1);

   // configuration registers
   logic signed [TRIG_W-1:0] cos_yaw_ff, sin_yaw_ff, cos_pitch_ff, sin_pitch_ff;
   logic signed [CTR_W-1:0]  center_x_ff, center_y_ff;
   logic [FOCAL_W-1:0]       focal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_yaw_ff   <= RST_COS;
         sin_yaw_ff   <= RST_SIN;
         cos_pitch_ff <= RST_COS;
         sin_pitch_ff <= RST_SIN;
         center_x_ff  <= RST_CTR;
         center_y_ff  <= RST_CTR;
         focal_ff     <= RST_FOCAL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COS_YAW:   cos_yaw_ff   <= csr_data[TRIG_W-1:0];
            CSR_SIN_YAW:   sin_yaw_ff   <= csr_data[TRIG_W-1:0];
            CSR_COS_PITCH: cos_pitch_ff <= csr_data[TRIG_W-1:0];
            CSR_SIN_PITCH: sin_pitch_ff <= csr_data[TRIG_W-1:0];
            CSR_CENTER_X:  center_x_ff  <= csr_data[CTR_W-1:0];
            CSR_CENTER_Y:  center_y_ff  <= csr_data[CTR_W-1:0];
            CSR_FOCAL:     focal_ff     <= csr_data[FOCAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // valid bits along the front stages
   logic [FRONT_STAGES-1:0] valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[FRONT_STAGES-2:0], start & ~busy};
      end
   end

   // last flag joins the tag at stage 7
   logic [FRONT_STAGES-2:0] last_ff;
   always_ff @(posedge clock) begin
      last_ff <= {last_ff[FRONT_STAGES-3:0], req_last_vertex};
   end

   // stage 1: yaw and y products
   logic signed [PROD_W-1:0] xcy_ff, zsy_ff, zcy_ff, xsy_ff, ycp_ff, ysp_ff;
   always_ff @(posedge clock) begin
      xcy_ff <= req_vertex_x * cos_yaw_ff;
      zsy_ff <= req_vertex_z * sin_yaw_ff;
      zcy_ff <= req_vertex_z * cos_yaw_ff;
      xsy_ff <= req_vertex_x * sin_yaw_ff;
      ycp_ff <= req_vertex_y * cos_pitch_ff;
      ysp_ff <= req_vertex_y * sin_pitch_ff;
   end

   // stage 2: yaw sums
   logic signed [ROT1_W-1:0] x1_s2_ff, z1_ff;
   logic signed [PROD_W-1:0] ycp_s2_ff, ysp_s2_ff;
   always_ff @(posedge clock) begin
      x1_s2_ff  <= ROT1_W'(xcy_ff) + ROT1_W'(zsy_ff);
      z1_ff     <= ROT1_W'(zcy_ff) - ROT1_W'(xsy_ff);
      ycp_s2_ff <= ycp_ff;
      ysp_s2_ff <= ysp_ff;
   end

   // stage 3: pitch products
   logic signed [Z1P_W-1:0]  z1sp_ff, z1cp_ff;
   logic signed [YP_W-1:0]   ycp_sh_ff, ysp_sh_ff;
   logic signed [ROT1_W-1:0] x1_s3_ff;
   always_ff @(posedge clock) begin
      z1sp_ff   <= z1_ff * sin_pitch_ff;
      z1cp_ff   <= z1_ff * cos_pitch_ff;
      ycp_sh_ff <= YP_W'(ycp_s2_ff) <<< T;
      ysp_sh_ff <= YP_W'(ysp_s2_ff) <<< T;
      x1_s3_ff  <= x1_s2_ff;
   end

   // stage 4: pitch sums
   logic signed [ROT2_W-1:0] y2_ff, z2_ff;
   logic signed [ROT1_W-1:0] x1_s4_ff;
   always_ff @(posedge clock) begin
      y2_ff    <= ROT2_W'(ycp_sh_ff) - ROT2_W'(z1sp_ff);
      z2_ff    <= ROT2_W'(ysp_sh_ff) + ROT2_W'(z1cp_ff);
      x1_s4_ff <= x1_s3_ff;
   end

   // stage 5: round half up, saturate, depth offset and clamp
   logic signed [ROT1_W:0]   x1r;
   logic signed [ROT2_W:0]   y2r;
   logic signed [DF_W-1:0]   dfull;
   logic signed [DF_W:0]     dr;
   logic signed [OUT_W-1:0]  x1q_in, y2q_in;
   logic [DEPTH_W-1:0]       d_in;

   always_comb begin
      x1r   = ((ROT1_W+1)'(x1_s4_ff) + HALF_X) >>> SX;
      y2r   = ((ROT2_W+1)'(y2_ff) + HALF_Y) >>> SY;
      dfull = DF_W'(z2_ff) + DEPTH_OFFSET;
      dr    = ((DF_W+1)'(dfull) + HALF_D) >>> SY;
      if (x1r > X_MAX) begin
         x1q_in = S32_MAX;
      end else if (x1r < X_MIN) begin
         x1q_in = S32_MIN;
      end else begin
         x1q_in = x1r[OUT_W-1:0];
      end
      if (y2r > Y_MAX) begin
         y2q_in = S32_MAX;
      end else if (y2r < Y_MIN) begin
         y2q_in = S32_MIN;
      end else begin
         y2q_in = y2r[OUT_W-1:0];
      end
      if (dr < R_MIN) begin
         d_in = DEPTH_W'(DEPTH_MIN);
      end else if (dr > R_MAX) begin
         d_in = DEPTH_MAX;
      end else begin
         d_in = dr[DEPTH_W-1:0];
      end
   end

   logic signed [OUT_W-1:0] x1q_ff, y2q_ff;
   logic [DEPTH_W-1:0]      d_s5_ff;
   always_ff @(posedge clock) begin
      x1q_ff  <= x1q_in;
      y2q_ff  <= y2q_in;
      d_s5_ff <= d_in;
   end

   // stage 6: magnitude times focal length
   logic [OUT_W-1:0] mag_x, mag_y;
   assign mag_x = x1q_ff[OUT_W-1] ? OUT_W'(-x1q_ff) : OUT_W'(x1q_ff);
   assign mag_y = y2q_ff[OUT_W-1] ? OUT_W'(-y2q_ff) : OUT_W'(y2q_ff);

   logic [NUM_W-1:0]   prod_x_ff, prod_y_ff;
   logic [DEPTH_W-1:0] d_s6_ff;
   logic               neg_x_s6_ff, neg_y_s6_ff;
   always_ff @(posedge clock) begin
      prod_x_ff   <= NUM_W'(mag_x) * NUM_W'(focal_ff);
      prod_y_ff   <= NUM_W'(mag_y) * NUM_W'(focal_ff);
      d_s6_ff     <= d_s5_ff;
      neg_x_s6_ff <= x1q_ff[OUT_W-1];
      neg_y_s6_ff <= y2q_ff[OUT_W-1];
   end

   // stage 7: add half the divisor for rounding to nearest
   logic [NUM_W-1:0]   num_x_ff, num_y_ff;
   logic [DEPTH_W-1:0] d_s7_ff;
   vrp_tag_type        tag_s7_ff;
   always_ff @(posedge clock) begin
      num_x_ff        <= prod_x_ff + NUM_W'(d_s6_ff >> 1);
      num_y_ff        <= prod_y_ff + NUM_W'(d_s6_ff >> 1);
      d_s7_ff         <= d_s6_ff;
      tag_s7_ff.last  <= last_ff[FRONT_STAGES-2];
      tag_s7_ff.neg_x <= neg_x_s6_ff;
      tag_s7_ff.neg_y <= neg_y_s6_ff;
   end

   logic               div_valid;
   vrp_tag_type        div_tag;
   logic [DEPTH_W-1:0] div_depth;
   logic [NUM_W-1:0]   quot_x, quot_y;

   vrp_div_pipe u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (valid_ff[FRONT_STAGES-1]),
      .in_tag      (tag_s7_ff),
      .in_divisor  (d_s7_ff),
      .in_num_x    (num_x_ff),
      .in_num_y    (num_y_ff),
      .out_valid   (div_valid),
      .out_tag     (div_tag),
      .out_divisor (div_depth),
      .out_quot_x  (quot_x),
      .out_quot_y  (quot_y)
   );

   // output stage: cap quotient, apply sign, add centre, saturate
   logic [QC_W-1:0]         qcap_x, qcap_y;
   logic signed [SUM_W-1:0] qs_x, qs_y, ctr_x, ctr_y, sum_x, sum_y;
   logic signed [OUT_W-1:0] sx_in, sy_in;

   always_comb begin
      qcap_x = (quot_x > Q_CAP) ? Q_CAP[QC_W-1:0] : quot_x[QC_W-1:0];
      qcap_y = (quot_y > Q_CAP) ? Q_CAP[QC_W-1:0] : quot_y[QC_W-1:0];
      qs_x   = div_tag.neg_x ? -SUM_W'(qcap_x) : SUM_W'(qcap_x);
      qs_y   = div_tag.neg_y ? -SUM_W'(qcap_y) : SUM_W'(qcap_y);
      ctr_x  = SUM_W'(center_x_ff) <<< OUT_FRAC;
      ctr_y  = SUM_W'(center_y_ff) <<< OUT_FRAC;
      sum_x  = ctr_x + qs_x;
      sum_y  = ctr_y - qs_y;
      if (sum_x > O_MAX) begin
         sx_in = S32_MAX;
      end else if (sum_x < O_MIN) begin
         sx_in = S32_MIN;
      end else begin
         sx_in = sum_x[OUT_W-1:0];
      end
      if (sum_y > O_MAX) begin
         sy_in = S32_MAX;
      end else if (sum_y < O_MIN) begin
         sy_in = S32_MIN;
      end else begin
         sy_in = sum_y[OUT_W-1:0];
      end
   end

   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [DEPTH_W-1:0]      rsp_depth_ff;
   logic                    rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff     <= sx_in;
      rsp_y_ff     <= sy_in;
      rsp_depth_ff <= div_depth;
      rsp_last_ff  <= div_tag.last;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_screen_x = rsp_x_ff;
   assign rsp_screen_y = rsp_y_ff;
   assign rsp_depth    = rsp_depth_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/vrp_checker.sv =====
// port-level assertions for the vertex rotate and project block, bound to the top level
// depends on vrp_pkg and vertex_rotate_project
`default_nettype none

module vrp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              req_last_vertex,
   input wire logic                              rsp_valid,
   input wire logic [vrp_pkg::DEPTH_W-1:0]       rsp_depth,
   input wire logic                              rsp_last_out
);
   import vrp_pkg::*;

   // every result beat matches an accepted beat a fixed latency earlier
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, LATENCY))
      else $error("result beat without matching accepted beat");

   // the last flag travels with its vertex
   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_out == $past(req_last_vertex, LATENCY))
      else $error("last flag out of step with its vertex");

   // depth never falls below the clamp
   a_depth_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_depth >= DEPTH_W'(DEPTH_MIN))
      else $error("depth below clamp");

   // reset flushes beats in flight
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (.*);

`default_nettype wire
